FILE: design/glyph_quad_text_layout_assert.svh
// ----------------------------------------------------------------------------
// glyph quad text layout assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_TEXT_LAYOUT_ASSERT_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define GQTL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("gqtl assertion failed");

// consequence that must hold in the cycle after the antecedent
`define GQTL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gqtl assertion failed");

`else

`define GQTL_ASSERT(label, clk, rstn, prop)
`define GQTL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: design/gqtl_pkg.sv
// ----------------------------------------------------------------------------
// gqtl_pkg
// shared types, codes and saturation helpers of the glyph quad text layout
// ----------------------------------------------------------------------------
`default_nettype none

package gqtl_pkg;

    // function codes carried on s_tuser
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_GLYPH  = 2'd1;
    localparam logic [1:0] FUNC_SETPEN = 2'd2;
    localparam logic [1:0] FUNC_REPORT = 2'd3;

    // character codes
    localparam logic [6:0] CODE_NEWLINE = 7'd10;
    localparam logic [6:0] CODE_FIRST   = 7'd32;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 3;
    localparam logic [2:0] REG_LINE_STEP  = 3'd0;
    localparam logic [2:0] REG_SCALE_X    = 3'd1;
    localparam logic [2:0] REG_SCALE_Y    = 3'd2;
    localparam logic [2:0] REG_WRAP_LIMIT = 3'd3;
    localparam logic [2:0] REG_INV_W      = 3'd4;
    localparam logic [2:0] REG_INV_H      = 3'd5;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [24:0]        TEX_MAX = 25'h1FF_FFFF;

    // stream widths
    localparam int S_DATA_W = 184;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 120;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // six vertices per quad
    localparam logic [2:0] VERT_LAST = 3'd5;

    typedef enum logic [1:0] {
        CMD_SETPEN,
        CMD_REPORT,
        CMD_NEWLINE,
        CMD_GLYPH
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_WRAP,
        B_EDGE,
        B_POS
    } back_state_t;

    typedef struct packed {
        logic        [15:0] col;
        logic signed [15:0] bt;
        logic signed [15:0] bl;
        logic        [14:0] bh;
        logic        [14:0] bw;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } glyph_t;

    typedef struct packed {
        cmd_kind_t          kind;
        glyph_t             glyph;
        logic signed [31:0] start_y;
        logic signed [31:0] start_x;
    } cmd_t;

    typedef struct packed {
        logic               single;
        logic        [24:0] v1;
        logic        [24:0] u1;
        logic        [24:0] u0;
        logic signed [31:0] y1;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] x0;
    } quad_t;

    typedef struct packed {
        logic        [2:0]  pad;
        logic signed [31:0] start_y;
        logic signed [31:0] start_x;
        logic        [15:0] atlas_column;
        logic signed [15:0] bearing_top;
        logic signed [15:0] bearing_left;
        logic        [14:0] box_height;
        logic        [14:0] box_width;
        logic signed [15:0] advance_y;
        logic signed [15:0] advance_x;
        logic        [6:0]  code;
    } in_data_t;

    typedef struct packed {
        logic        [5:0]  pad;
        logic        [24:0] tex_v;
        logic        [24:0] tex_u;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_x;
    } out_data_t;

    // clamp a wide signed value to the 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (&v[42:31] || ~|v[42:31]) begin
            return $signed(v[31:0]);
        end
        return v[42] ? S32_MIN : S32_MAX;
    endfunction

    // clamp a texture coordinate to 25 bits
    function automatic logic [24:0] sat_tex(input logic [41:0] v);
        if (|v[41:25]) begin
            return TEX_MAX;
        end
        return v[24:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/glyph_quad_text_layout.sv
// a glyph passes the front stage register, the queue, the back states and emitter buffers
// the result port sends one vertex per cycle while m_tready is high
// a report is a single vertex with tlast set; loads, pen moves and ignored codes send nothing
// back states B_MUL, B_WRAP, B_EDGE and B_POS overlap emission of the previous glyph
// reset: synchronous active low, glyph table reads zero at once via per-entry valid bits
// ----------------------------------------------------------------------------
// glyph_quad_text_layout
// text layout engine emitting six textured-quad vertices per visible glyph
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_text_layout #(
    parameter int GLYPH_COUNT = 96
) (
    input  wire                            aclk,
    input  wire                            aresetn,

    // configuration write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [gqtl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [31:0]                    cfg_data,

    // input stream
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // code[6:0] advance_x[22:7] advance_y[38:23] box_width[53:39]
    // box_height[68:54] bearing_left[84:69] bearing_top[100:85]
    // atlas_column[116:101] start_x[148:117] start_y[180:149], zero above
    input  wire  [gqtl_pkg::S_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  wire  [gqtl_pkg::S_USER_W-1:0]  s_tuser,

    // result stream
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // vert_x[31:0] vert_y[63:32] tex_u[88:64] tex_v[113:89], zero above
    output logic [gqtl_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    // front stage to queue
    logic            fq_valid;
    logic            fq_ready;
    gqtl_pkg::cmd_t  fq_cmd;

    // queue to back sequencer
    logic            qb_valid;
    logic            qb_ready;
    gqtl_pkg::cmd_t  qb_cmd;

    // back sequencer to vertex emitter
    logic            be_valid;
    logic            be_ready;
    gqtl_pkg::quad_t be_quad;

    // front: takes one transfer a cycle while its stage register can drain, writes
    // load items into the metrics memory, drops ignored codes and hands pen and
    // glyph commands onward with the glyph metrics already read out
    gqtl_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    // queue: lets the front keep taking items while the back works on a glyph
    gqtl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // back: owns the registers and the pen, resolves wrap, multiplies the
    // metrics by the scales and reciprocals and clamps the quad corners
    gqtl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_cmd      (qb_cmd),
        .quad_valid (be_valid),
        .quad_ready (be_ready),
        .quad       (be_quad)
    );

    // emitter: one quad waiting plus one being sent, so the next glyph's
    // corners are ready by the time the sixth vertex transfers
    gqtl_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .quad_valid (be_valid),
        .quad_ready (be_ready),
        .quad       (be_quad),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: design/gqtl_front.sv
// ----------------------------------------------------------------------------
// gqtl_front
// input acceptance, classification and glyph metrics memory
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_quad_text_layout_assert.svh"

module gqtl_front #(
    parameter int GLYPH_COUNT = 96
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [gqtl_pkg::S_DATA_W-1:0] s_tdata,
    input  wire  [gqtl_pkg::S_USER_W-1:0] s_tuser,
    output logic                          q_valid,
    input  wire                           q_ready,
    output gqtl_pkg::cmd_t                q_cmd
);

    localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    gqtl_pkg::in_data_t    din;
    logic [7:0]            idx_full;
    logic [IDX_W-1:0]      idx;
    logic                  in_table;
    logic                  accept;
    logic                  fwd;
    logic                  wr_en;
    gqtl_pkg::cmd_kind_t   kind;
    gqtl_pkg::glyph_t      wr_glyph;

    gqtl_pkg::glyph_t      glyph_mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] glyph_live_reg;
    gqtl_pkg::glyph_t      rd_data_reg;
    logic                  rd_live_reg;

    logic                  st_valid_reg;
    gqtl_pkg::cmd_kind_t   st_kind_reg;
    logic signed [31:0]    st_start_x_reg;
    logic signed [31:0]    st_start_y_reg;

    assign din      = s_tdata;
    assign idx_full = {1'b0, din.code} - {1'b0, gqtl_pkg::CODE_FIRST};
    assign in_table = (din.code >= gqtl_pkg::CODE_FIRST) && (idx_full < 8'(GLYPH_COUNT));
    assign idx      = idx_full[IDX_W-1:0];

    assign s_tready = !st_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // sort the item: loads and glyph codes outside the table, newline apart, stop here
    always_comb begin
        fwd   = 1'b0;
        wr_en = 1'b0;
        kind  = gqtl_pkg::CMD_GLYPH;
        unique case (s_tuser)
            gqtl_pkg::FUNC_LOAD: begin
                wr_en = in_table;
            end
            gqtl_pkg::FUNC_GLYPH: begin
                if (din.code == gqtl_pkg::CODE_NEWLINE) begin
                    kind = gqtl_pkg::CMD_NEWLINE;
                    fwd  = 1'b1;
                end else begin
                    fwd = in_table;
                end
            end
            gqtl_pkg::FUNC_SETPEN: begin
                kind = gqtl_pkg::CMD_SETPEN;
                fwd  = 1'b1;
            end
            gqtl_pkg::FUNC_REPORT: begin
                kind = gqtl_pkg::CMD_REPORT;
                fwd  = 1'b1;
            end
        endcase
    end

    always_comb begin
        wr_glyph.col = din.atlas_column;
        wr_glyph.bt  = din.bearing_top;
        wr_glyph.bl  = din.bearing_left;
        wr_glyph.bh  = din.box_height;
        wr_glyph.bw  = din.box_width;
        wr_glyph.ay  = din.advance_y;
        wr_glyph.ax  = din.advance_x;
    end

    // metrics memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            glyph_mem[idx] <= wr_glyph;
        end
        if (accept) begin
            rd_data_reg <= glyph_mem[idx];
            rd_live_reg <= glyph_live_reg[idx];
        end
    end

    // entries never loaded read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_live_reg <= '0;
        end else if (accept && wr_en) begin
            glyph_live_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= fwd;
        end else if (q_ready) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_kind_reg    <= kind;
            st_start_x_reg <= din.start_x;
            st_start_y_reg <= din.start_y;
        end
    end

    assign q_valid       = st_valid_reg;
    assign q_cmd.kind    = st_kind_reg;
    assign q_cmd.glyph   = rd_live_reg ? rd_data_reg : '0;
    assign q_cmd.start_x = st_start_x_reg;
    assign q_cmd.start_y = st_start_y_reg;

    `GQTL_ASSERT_NEXT(a_front_stall_hold, aclk, aresetn, st_valid_reg && !q_ready, st_valid_reg && $stable(st_kind_reg))

endmodule

`default_nettype wire

FILE: design/gqtl_queue.sv
// ----------------------------------------------------------------------------
// gqtl_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_quad_text_layout_assert.svh"

module gqtl_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  gqtl_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  wire             out_ready,
    output gqtl_pkg::cmd_t  out_cmd
);

    gqtl_pkg::cmd_t                slot_mem [gqtl_pkg::QUEUE_DEPTH];
    logic [gqtl_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [gqtl_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [gqtl_pkg::QCNT_W-1:0]   count_reg;
    logic                          push;
    logic                          pop;

    assign in_ready  = count_reg != gqtl_pkg::QCNT_W'(gqtl_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `GQTL_ASSERT(a_queue_count, aclk, aresetn, count_reg <= gqtl_pkg::QCNT_W'(gqtl_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

FILE: design/gqtl_back.sv
// ----------------------------------------------------------------------------
// gqtl_back
// configuration registers, pen state and quad arithmetic sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module gqtl_back (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [gqtl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [31:0]                    cfg_data,
    input  wire                            q_valid,
    output logic                           q_ready,
    input  gqtl_pkg::cmd_t                 q_cmd,
    output logic                           quad_valid,
    input  wire                            quad_ready,
    output gqtl_pkg::quad_t                quad
);

    // configuration
    logic [30:0]        line_step_reg;
    logic [23:0]        scale_x_reg;
    logic [23:0]        scale_y_reg;
    logic signed [31:0] wrap_limit_reg;
    logic [24:0]        inv_w_reg;
    logic [24:0]        inv_h_reg;

    // pen
    logic signed [31:0] pen_x_reg;
    logic signed [31:0] pen_y_reg;
    logic signed [31:0] line_x_reg;

    gqtl_pkg::back_state_t state_reg;
    gqtl_pkg::back_state_t state_next;

    gqtl_pkg::glyph_t   g_reg;
    logic signed [40:0] p_bl_sx_reg;
    logic signed [40:0] p_bt_sy_reg;
    logic signed [40:0] p_ax_sx_reg;
    logic signed [40:0] p_ay_sy_reg;
    logic [38:0]        w_reg;
    logic [38:0]        h_reg;
    logic [40:0]        p_col_iw_reg;
    logic [39:0]        p_bw_iw_reg;
    logic [39:0]        p_bh_ih_reg;
    logic [24:0]        u0_reg;
    logic [24:0]        u1_reg;
    logic [24:0]        v1_reg;
    logic signed [41:0] xl_reg;
    logic signed [41:0] yt_reg;

    logic signed [24:0] sx_s;
    logic signed [24:0] sy_s;
    logic signed [42:0] wrap_sum;
    logic               wrap;
    logic signed [31:0] y_dropped;
    logic               empty;
    logic               pop;
    logic               is_report;

    assign cfg_ready = 1'b1;

    assign sx_s      = $signed({1'b0, scale_x_reg});
    assign sy_s      = $signed({1'b0, scale_y_reg});
    assign wrap_sum  = 43'(pen_x_reg) + (43'(p_bl_sx_reg) <<< 1);
    assign wrap      = 43'(wrap_limit_reg) <= wrap_sum;
    assign y_dropped = gqtl_pkg::sat32(43'(pen_y_reg) - 43'($signed({1'b0, line_step_reg})));
    assign empty     = (w_reg == '0) || (h_reg == '0);
    assign is_report = q_cmd.kind == gqtl_pkg::CMD_REPORT;
    assign pop       = q_valid && q_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gqtl_pkg::B_IDLE: begin
                if (pop && q_cmd.kind == gqtl_pkg::CMD_GLYPH) begin
                    state_next = gqtl_pkg::B_MUL;
                end
            end
            gqtl_pkg::B_MUL:  state_next = gqtl_pkg::B_WRAP;
            gqtl_pkg::B_WRAP: state_next = gqtl_pkg::B_EDGE;
            gqtl_pkg::B_EDGE: state_next = gqtl_pkg::B_POS;
            gqtl_pkg::B_POS: begin
                if (empty || quad_ready) begin
                    state_next = gqtl_pkg::B_IDLE;
                end
            end
            default: state_next = gqtl_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_ready    = 1'b0;
        quad_valid = 1'b0;
        quad       = '0;
        unique case (state_reg)
            gqtl_pkg::B_IDLE: begin
                q_ready     = !is_report || quad_ready;
                quad_valid  = q_valid && is_report;
                quad.single = 1'b1;
                quad.x0     = pen_x_reg;
                quad.y0     = pen_y_reg;
            end
            gqtl_pkg::B_POS: begin
                quad_valid = !empty;
                quad.x0    = gqtl_pkg::sat32(43'(xl_reg));
                quad.x1    = gqtl_pkg::sat32(43'(xl_reg) + 43'($signed({1'b0, w_reg})));
                quad.y0    = gqtl_pkg::sat32(43'(yt_reg));
                quad.y1    = gqtl_pkg::sat32(43'(yt_reg) - 43'($signed({1'b0, h_reg})));
                quad.u0    = u0_reg;
                quad.u1    = u1_reg;
                quad.v1    = v1_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gqtl_pkg::B_IDLE;
            line_step_reg  <= '0;
            scale_x_reg    <= '0;
            scale_y_reg    <= '0;
            wrap_limit_reg <= gqtl_pkg::S32_MAX;
            inv_w_reg      <= '0;
            inv_h_reg      <= '0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            line_x_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    gqtl_pkg::REG_LINE_STEP:  line_step_reg  <= cfg_data[30:0];
                    gqtl_pkg::REG_SCALE_X:    scale_x_reg    <= cfg_data[23:0];
                    gqtl_pkg::REG_SCALE_Y:    scale_y_reg    <= cfg_data[23:0];
                    gqtl_pkg::REG_WRAP_LIMIT: wrap_limit_reg <= $signed(cfg_data);
                    gqtl_pkg::REG_INV_W:      inv_w_reg      <= cfg_data[24:0];
                    gqtl_pkg::REG_INV_H:      inv_h_reg      <= cfg_data[24:0];
                    default: begin
                    end
                endcase
            end
            // pen moves in command order
            if (pop && q_cmd.kind == gqtl_pkg::CMD_SETPEN) begin
                pen_x_reg  <= q_cmd.start_x;
                line_x_reg <= q_cmd.start_x;
                pen_y_reg  <= q_cmd.start_y;
            end else if (pop && q_cmd.kind == gqtl_pkg::CMD_NEWLINE) begin
                pen_x_reg <= line_x_reg;
                pen_y_reg <= y_dropped;
            end else if (state_reg == gqtl_pkg::B_WRAP && wrap) begin
                pen_x_reg <= line_x_reg;
                pen_y_reg <= y_dropped;
            end else if (state_reg == gqtl_pkg::B_EDGE) begin
                pen_x_reg <= gqtl_pkg::sat32(43'(pen_x_reg) + 43'(p_ax_sx_reg));
                pen_y_reg <= gqtl_pkg::sat32(43'(pen_y_reg) + 43'(p_ay_sy_reg));
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (pop) begin
            g_reg <= q_cmd.glyph;
        end
        if (state_reg == gqtl_pkg::B_MUL) begin
            p_bl_sx_reg  <= $signed(g_reg.bl) * sx_s;
            p_bt_sy_reg  <= $signed(g_reg.bt) * sy_s;
            p_ax_sx_reg  <= $signed(g_reg.ax) * sx_s;
            p_ay_sy_reg  <= $signed(g_reg.ay) * sy_s;
            w_reg        <= g_reg.bw * scale_x_reg;
            h_reg        <= g_reg.bh * scale_y_reg;
            p_col_iw_reg <= g_reg.col * inv_w_reg;
            p_bw_iw_reg  <= g_reg.bw * inv_w_reg;
            p_bh_ih_reg  <= g_reg.bh * inv_h_reg;
        end
        if (state_reg == gqtl_pkg::B_WRAP) begin
            u0_reg <= gqtl_pkg::sat_tex(42'(p_col_iw_reg));
            u1_reg <= gqtl_pkg::sat_tex(42'(p_col_iw_reg) + 42'(p_bw_iw_reg));
            v1_reg <= gqtl_pkg::sat_tex(42'(p_bh_ih_reg));
        end
        if (state_reg == gqtl_pkg::B_EDGE) begin
            xl_reg <= 42'(pen_x_reg) + 42'(p_bl_sx_reg);
            yt_reg <= 42'(pen_y_reg) + 42'(p_bt_sy_reg);
        end
    end

endmodule

`default_nettype wire

FILE: design/gqtl_emit.sv
// ----------------------------------------------------------------------------
// gqtl_emit
// quad buffer and vertex serializer driving the result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_quad_text_layout_assert.svh"

module gqtl_emit (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           quad_valid,
    output logic                          quad_ready,
    input  gqtl_pkg::quad_t               quad,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [gqtl_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    // vertex order x0y0 x1y0 x0y1 x1y0 x0y1 x1y1
    localparam logic [5:0] X1_MASK = 6'b101010;
    localparam logic [5:0] Y1_MASK = 6'b110100;

    logic              pend_valid_reg;
    gqtl_pkg::quad_t   pend_reg;
    logic              rec_valid_reg;
    gqtl_pkg::quad_t   rec_reg;
    logic [2:0]        cnt_reg;

    logic              fire;
    logic              rec_free;
    logic              move;
    logic              take;
    logic              use_x1;
    logic              use_y1;
    gqtl_pkg::out_data_t dout;

    assign use_x1 = X1_MASK[cnt_reg];
    assign use_y1 = Y1_MASK[cnt_reg];

    always_comb begin
        dout        = '0;
        dout.vert_x = use_x1 ? rec_reg.x1 : rec_reg.x0;
        dout.vert_y = use_y1 ? rec_reg.y1 : rec_reg.y0;
        dout.tex_u  = use_x1 ? rec_reg.u1 : rec_reg.u0;
        dout.tex_v  = use_y1 ? rec_reg.v1 : '0;
    end

    assign m_tdata  = dout;
    assign m_tvalid = rec_valid_reg;
    assign m_tlast  = rec_reg.single || (cnt_reg == gqtl_pkg::VERT_LAST);

    assign fire       = m_tvalid && m_tready;
    assign rec_free   = !rec_valid_reg || (fire && m_tlast);
    assign move       = pend_valid_reg && rec_free;
    assign quad_ready = !pend_valid_reg;
    assign take       = quad_valid && quad_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            rec_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (move) begin
                pend_valid_reg <= 1'b0;
            end else if (take) begin
                pend_valid_reg <= 1'b1;
            end
            if (rec_free) begin
                rec_valid_reg <= move;
                cnt_reg       <= '0;
            end else if (fire) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pend_reg <= quad;
        end
        if (move) begin
            rec_reg <= pend_reg;
        end
    end

    `GQTL_ASSERT(a_emit_cnt_range, aclk, aresetn, !rec_valid_reg || cnt_reg <= gqtl_pkg::VERT_LAST)
    `GQTL_ASSERT(a_emit_single_first, aclk, aresetn, !rec_valid_reg || !rec_reg.single || cnt_reg == '0)
    `GQTL_ASSERT_NEXT(a_emit_pend_hold, aclk, aresetn, pend_valid_reg && !rec_free, pend_valid_reg && $stable(pend_reg))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// glyph quad text layout testbench
// drives loads, glyphs, newlines, pen moves and pen reports through the input
// stream under random stalls on both sides, predicts every vertex in fixed
// point and compares each result transfer field by field
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import gqtl_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 2;
    localparam int GLYPH_SLOTS    = 96;
    localparam int PHASE_ITEMS    = 76;
    localparam int PHASE_COUNT    = 5;
    // pipeline plus a full command queue of silent items, with margin
    localparam int SETTLE_CYCLES  = 48;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 300;
    // longest legal stretch without any transfer is the hold-off above
    localparam int WATCHDOG_LIMIT = 3000;

    // register indexes the block must ignore
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // one vertex as it leaves the result stream
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [24:0] u;
        logic        [24:0] v;
        logic               last;
    } vertex_t;

    // one row of the directed stimulus table
    typedef struct {
        logic [1:0] fn;
        in_data_t   d;
        bit         typed;
        longint     want_x;
        longint     want_y;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]         cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [S_USER_W-1:0] s_tuser   = '0;
    logic                m_tready  = 1'b0;

    wire                 cfg_ready;
    wire                 s_tready;
    wire                 m_tvalid;
    wire [M_DATA_W-1:0]  m_tdata;
    wire                 m_tlast;

    always #HALF_PERIOD aclk = ~aclk;

    glyph_quad_text_layout #(
        .GLYPH_COUNT (GLYPH_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------------
    // layout state mirrored from the block, held as wide signed integers
    // ------------------------------------------------------------------------
    longint line_step_q = 0;
    longint scale_x_q   = 0;
    longint scale_y_q   = 0;
    longint wrap_q      = 2147483647;
    longint inv_w_q     = 0;
    longint inv_h_q     = 0;

    longint pen_x        = 0;
    longint pen_y        = 0;
    longint line_start_x = 0;
    glyph_t glyph_tab [GLYPH_SLOTS] = '{default: '0};

    vertex_t   pending_vertices[$];
    plan_row_t plan[$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    int send_run     = 0;
    bit hold_off_req = 1'b0;

    // ------------------------------------------------------------------------
    // fixed point helpers
    // ------------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > longint'(S32_MAX)) begin
            return longint'(S32_MAX);
        end
        if (v < longint'(S32_MIN)) begin
            return longint'(S32_MIN);
        end
        return v;
    endfunction

    function automatic longint clamp_texel(input longint v);
        return (v > longint'(TEX_MAX)) ? longint'(TEX_MAX) : v;
    endfunction

    function automatic void queue_vertex(input longint x, input longint y,
                                         input longint u, input longint v,
                                         input bit last);
        vertex_t vx;
        vx.x    = x[31:0];
        vx.y    = y[31:0];
        vx.u    = u[24:0];
        vx.v    = v[24:0];
        vx.last = last;
        pending_vertices.push_back(vx);
    endfunction

    // ------------------------------------------------------------------------
    // vertex predictor: updates pen and glyph table for one accepted item and
    // queues the vertices that it produces
    // ------------------------------------------------------------------------
    task automatic predict_layout(input logic [1:0] fn, input in_data_t d);
        glyph_t g;
        int     slot;
        longint bw, bh, bl, bt, ax, ay, col;
        longint w, h, xl, yt, x0, x1, y0, y1, u0, u1, v1;
        slot = int'(d.code) - int'(CODE_FIRST);
        if (fn == FUNC_SETPEN) begin
            pen_x        = longint'(d.start_x);
            line_start_x = pen_x;
            pen_y        = longint'(d.start_y);
        end else if (fn == FUNC_REPORT) begin
            queue_vertex(pen_x, pen_y, 0, 0, 1'b1);
        end else if (fn == FUNC_GLYPH && d.code == CODE_NEWLINE) begin
            pen_x = line_start_x;
            pen_y = clamp_coord(pen_y - line_step_q);
        end else if (d.code >= CODE_FIRST && slot < GLYPH_SLOTS) begin
            // codes below the table, newline loads included, fall through silently
            if (fn == FUNC_LOAD) begin
                glyph_tab[slot].ax  = d.advance_x;
                glyph_tab[slot].ay  = d.advance_y;
                glyph_tab[slot].bw  = d.box_width;
                glyph_tab[slot].bh  = d.box_height;
                glyph_tab[slot].bl  = d.bearing_left;
                glyph_tab[slot].bt  = d.bearing_top;
                glyph_tab[slot].col = d.atlas_column;
            end else begin
                g   = glyph_tab[slot];
                bw  = longint'(g.bw);
                bh  = longint'(g.bh);
                bl  = longint'(g.bl);
                bt  = longint'(g.bt);
                ax  = longint'(g.ax);
                ay  = longint'(g.ay);
                col = longint'(g.col);
                // wrap test uses twice the scaled left bearing, compared exactly
                if (wrap_q <= pen_x + 2 * bl * scale_x_q) begin
                    pen_x = line_start_x;
                    pen_y = clamp_coord(pen_y - line_step_q);
                end
                w  = bw * scale_x_q;
                h  = bh * scale_y_q;
                xl = pen_x + bl * scale_x_q;
                yt = pen_y + bt * scale_y_q;
                x0 = clamp_coord(xl);
                x1 = clamp_coord(xl + w);
                y0 = clamp_coord(yt);
                y1 = clamp_coord(yt - h);
                u0 = clamp_texel(col * inv_w_q);
                u1 = clamp_texel(col * inv_w_q + bw * inv_w_q);
                v1 = clamp_texel(bh * inv_h_q);
                pen_x = clamp_coord(pen_x + ax * scale_x_q);
                pen_y = clamp_coord(pen_y + ay * scale_y_q);
                // empty box: pen moves, nothing is drawn
                if (w != 0 && h != 0) begin
                    queue_vertex(x0, y0, u0, 0, 1'b0);
                    queue_vertex(x1, y0, u1, 0, 1'b0);
                    queue_vertex(x0, y1, u0, v1, 1'b0);
                    queue_vertex(x1, y0, u1, 0, 1'b0);
                    queue_vertex(x0, y1, u0, v1, 1'b0);
                    queue_vertex(x1, y1, u1, v1, 1'b1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // idle draws: a random gap before each item, with runs of back-to-back items
    // ------------------------------------------------------------------------
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // ------------------------------------------------------------------------
    // input stream driver: offer one item, wait for its transfer, predict it
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] fn, input in_data_t d);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        // ready is stable at the falling edge, the transfer lands on the next rise
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_layout(fn, d);
    endtask

    // ------------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        case (idx)
            REG_LINE_STEP:  line_step_q = longint'(data[30:0]);
            REG_SCALE_X:    scale_x_q   = longint'(data[23:0]);
            REG_SCALE_Y:    scale_y_q   = longint'(data[23:0]);
            REG_WRAP_LIMIT: wrap_q      = longint'($signed(data));
            REG_INV_W:      inv_w_q     = longint'(data[24:0]);
            REG_INV_H:      inv_h_q     = longint'(data[24:0]);
            default:        ;
        endcase
    endtask

    // full register set, plus the two spare indexes with junk that must not land
    task automatic program_regs(input logic [31:0] ls, input logic [31:0] sx,
                                input logic [31:0] sy, input logic [31:0] wl,
                                input logic [31:0] iw, input logic [31:0] ih);
        write_reg(REG_LINE_STEP, ls);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_WRAP_LIMIT, wl);
        write_reg(REG_INV_W, iw);
        write_reg(REG_INV_H, ih);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // wait for every vertex, then let silent items still in the queue retire
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // directed table builders
    // ------------------------------------------------------------------------
    function automatic void plan_load(input int code, input int ax, input int ay,
                                      input int bw, input int bh, input int bl,
                                      input int bt, input int col);
        plan_row_t r;
        r.fn             = FUNC_LOAD;
        r.d              = '0;
        r.d.code         = code[6:0];
        r.d.advance_x    = ax[15:0];
        r.d.advance_y    = ay[15:0];
        r.d.box_width    = bw[14:0];
        r.d.box_height   = bh[14:0];
        r.d.bearing_left = bl[15:0];
        r.d.bearing_top  = bt[15:0];
        r.d.atlas_column = col[15:0];
        r.typed          = 1'b0;
        plan.push_back(r);
    endfunction

    function automatic void plan_glyph(input int code);
        plan_row_t r;
        r.fn     = FUNC_GLYPH;
        r.d      = '0;
        r.d.code = code[6:0];
        r.typed  = 1'b0;
        plan.push_back(r);
    endfunction

    function automatic void plan_setpen(input logic [31:0] x, input logic [31:0] y);
        plan_row_t r;
        r.fn        = FUNC_SETPEN;
        r.d         = '0;
        r.d.start_x = x;
        r.d.start_y = y;
        r.typed     = 1'b0;
        plan.push_back(r);
    endfunction

    // report, optionally with the pen position written out by hand
    function automatic void plan_report(input bit typed, input longint x, input longint y);
        plan_row_t r;
        r.fn     = FUNC_REPORT;
        r.d      = '0;
        r.typed  = typed;
        r.want_x = x;
        r.want_y = y;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // random item generation
    // ------------------------------------------------------------------------
    // mostly small values, sometimes every bit of the field at random
    function automatic logic [31:0] pick_value(input int span, input bit signed_f);
        int v;
        if ($urandom_range(0, 5) == 0) begin
            return $urandom;
        end
        if (signed_f) begin
            v = int'($urandom_range(0, 2 * span)) - span;
        end else begin
            v = $urandom_range(0, span);
        end
        return v;
    endfunction

    // favor a small set of codes so loaded glyphs get drawn again and again
    function automatic logic [6:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 7'(32 + $urandom_range(0, 15));
        end
        if (r < 9) begin
            return 7'($urandom_range(32, 127));
        end
        return 7'($urandom_range(0, 31));
    endfunction

    task automatic send_random_item();
        in_data_t   d;
        logic [1:0] fn;
        int         pick;
        d              = '0;
        d.code         = pick_code();
        d.advance_x    = 16'(pick_value(40, 1'b1));
        d.advance_y    = 16'(pick_value(40, 1'b1));
        d.box_width    = 15'(pick_value(40, 1'b0));
        d.box_height   = 15'(pick_value(40, 1'b0));
        d.bearing_left = 16'(pick_value(40, 1'b1));
        d.bearing_top  = 16'(pick_value(40, 1'b1));
        d.atlas_column = 16'(pick_value(2000, 1'b0));
        d.start_x      = pick_value(1 << 26, 1'b1);
        d.start_y      = pick_value(1 << 26, 1'b1);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            fn = FUNC_LOAD;
        end else if (pick < 72) begin
            fn = FUNC_GLYPH;
            // a slice of layout items become newlines
            if (pick >= 67) begin
                d.code = CODE_NEWLINE;
            end
        end else if (pick < 82) begin
            fn = FUNC_SETPEN;
        end else begin
            fn = FUNC_REPORT;
        end
        send_item(fn, d);
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random stalls per vertex, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        int rcv_run;
        rcv_run = 0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            stall = draw_wait(rcv_run);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // result checker and watchdog, sampled at the falling edge where every
    // signal is settled for the coming rising edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : check_results
        out_data_t beat;
        vertex_t   want;
        beat = out_data_t'(m_tdata);
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_vertices.size() == 0) begin
                    $display("%0t: vertex expected none actual x=%h y=%h u=%h v=%h last=%b",
                             $time, beat.vert_x, beat.vert_y, beat.tex_u, beat.tex_v,
                             m_tlast);
                    mismatches++;
                end else begin
                    want = pending_vertices.pop_front();
                    if (beat.vert_x !== want.x) begin
                        $display("%0t: vert_x expected %h actual %h",
                                 $time, want.x, beat.vert_x);
                        mismatches++;
                    end
                    if (beat.vert_y !== want.y) begin
                        $display("%0t: vert_y expected %h actual %h",
                                 $time, want.y, beat.vert_y);
                        mismatches++;
                    end
                    if (beat.tex_u !== want.u) begin
                        $display("%0t: tex_u expected %h actual %h",
                                 $time, want.u, beat.tex_u);
                        mismatches++;
                    end
                    if (beat.tex_v !== want.v) begin
                        $display("%0t: tex_v expected %h actual %h",
                                 $time, want.v, beat.tex_v);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: tlast expected %b actual %b",
                                 $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            // any transfer on any channel counts as progress
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d vertices still expected",
                         $time, pending_vertices.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: reset, directed table, then randomized register phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // scale 1/256, one line per newline, wrap at 16.0, small texel steps
        program_regs(32'h0100_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h1000_0000, 32'h0000_1000, 32'h0000_1000);

        plan_report(1'b1, 0, 0);                         // pen after reset
        plan_glyph(65);                                  // never loaded: empty box
        plan_setpen(S32_MAX, S32_MIN);
        plan_report(1'b1, longint'(S32_MAX), longint'(S32_MIN));
        plan_glyph(int'(CODE_NEWLINE));                  // drop clamps at the bottom
        plan_report(1'b1, longint'(S32_MAX), longint'(S32_MIN));
        // first and last table slots with opposite field extremes
        plan_load(32, -32768, 32767, 32767, 32767, -32768, 32767, 65535);
        plan_load(127, 32767, -32768, 1, 1, 32767, -32768, 0);
        plan_load(int'(CODE_NEWLINE), 9, 9, 9, 9, 9, 9, 9); // newline load is dropped
        plan_load(0, 9, 9, 9, 9, 9, 9, 9);              // codes below the table
        plan_load(31, 9, 9, 9, 9, 9, 9, 9);
        plan_glyph(32);                                  // saturating coordinates
        plan_glyph(127);                                 // large bearing forces a wrap
        plan_glyph(5);
        plan_glyph(31);
        plan_setpen(32'h0, 32'h0);
        plan_glyph(127);
        plan_load(33, 5, 0, 0, 20, 0, 0, 7);             // zero width box
        plan_glyph(33);                                  // pen advances, no quad
        plan_load(64, 10, 3, 8, 12, 1, 10, 100);
        plan_glyph(64);
        plan_setpen(S32_MIN, S32_MAX);
        plan_glyph(64);
        plan_report(1'b0, 0, 0);

        foreach (plan[i]) begin
            send_item(plan[i].fn, plan[i].d);
            // hand-written pen position replaces the predicted report
            if (plan[i].typed) begin
                pending_vertices[pending_vertices.size() - 1] =
                    '{x: plan[i].want_x[31:0], y: plan[i].want_y[31:0],
                      u: '0, v: '0, last: 1'b1};
            end
        end
        settle();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: program_regs($urandom_range(1 << 20, 1 << 25),
                                $urandom_range(1 << 12, 1 << 18),
                                $urandom_range(1 << 12, 1 << 18),
                                $urandom_range(1 << 25, 1 << 28),
                                $urandom_range(1 << 8, 1 << 16),
                                $urandom_range(1 << 8, 1 << 16));
                // all ones, upper bits beyond each register included; wrap limit at S32_MIN
                1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                S32_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                // all zero: no quad can be drawn, every glyph wraps at pen >= 0
                2: program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                3: program_regs($urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
                // wrap limit at S32_MAX, reciprocal at exactly one
                default: program_regs($urandom_range(1 << 20, 1 << 25),
                                      $urandom_range(1 << 10, 1 << 20),
                                      $urandom_range(1 << 10, 1 << 20),
                                      S32_MAX, 32'h0100_0000, 32'h0100_0000);
            endcase
            // back the block up once while the sender keeps offering
            if (phase == 0) begin
                hold_off_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_random_item();
            settle();
        end

        if (mismatches == 0 && pending_vertices.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: glyph_quad_text_layout.f
+incdir+design
design/gqtl_pkg.sv
design/gqtl_front.sv
design/gqtl_queue.sv
design/gqtl_back.sv
design/gqtl_emit.sv
design/glyph_quad_text_layout.sv
tb/testbench.sv
